>>> hw/rtl/shape_pixel_rasterizer_unit_macros.svh
// Assertion macros shared by the shape pixel rasterizer checker.
`ifndef SHAPE_PIXEL_RASTERIZER_UNIT_MACROS_SVH
`define SHAPE_PIXEL_RASTERIZER_UNIT_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define SPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("shape_pixel_rasterizer_unit: assertion failed");

// Clocked on clk, checked during reset as well.
`define SPR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("shape_pixel_rasterizer_unit: assertion failed");

`endif

>>> hw/rtl/spr_pkg.sv
// Shared types, widths and codes of the shape pixel rasterizer.
package spr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RAD_BITS    = COORD_BITS - 1;
  localparam int X_BITS      = 16;
  localparam int COLOR_BITS  = 8;
  localparam int SQ_BITS     = 2 * RAD_BITS;
  localparam int REM_BITS    = RAD_BITS + 1;
  localparam int CNT_BITS    = $clog2(RAD_BITS);

  // Input beat layout
  localparam int CX_LSB      = 0;
  localparam int CY_LSB      = CX_LSB + COORD_BITS;
  localparam int RAD_LSB     = CY_LSB + COORD_BITS;
  localparam int COL_LSB     = RAD_LSB + RAD_BITS;
  localparam int IN_FIELDS_W = COL_LSB + COLOR_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 3;

  // Output beat layout
  localparam int OUT_FIELDS_W = 2 * X_BITS + COLOR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration
  localparam int CFG_IDX_BITS = 1;
  localparam logic [COORD_BITS-1:0] FRAME_COLS_RST = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] FRAME_ROWS_RST = COORD_BITS'(480);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_CMD  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    SHAPE_PIXEL   = 2'd0,
    SHAPE_OUTLINE = 2'd1,
    SHAPE_DISC    = 2'd2,
    SHAPE_FILL    = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_MUL,
    ST_LOAD,
    ST_ITER,
    ST_SPAN
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic load_en;
    logic iter_en;
    logic span_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic row_start;
    logic iter_done;
  } dp_status_t;

endpackage

>>> hw/rtl/spr_isqrt.sv
// Row half-span unit: squares, then a bit-serial integer square root.
module spr_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  spr_pkg::dp_cmd_t             cmd,
  input  logic [spr_pkg::X_BITS-1:0]   row_pos,
  input  logic [spr_pkg::COORD_BITS-1:0] center_y,
  input  logic [spr_pkg::RAD_BITS-1:0] radius,
  output logic [spr_pkg::RAD_BITS-1:0] root,
  output logic                         done
);
  import spr_pkg::*;

  logic [X_BITS-1:0]     dy_wide;
  logic [RAD_BITS-1:0]   dy;
  logic [SQ_BITS-1:0]    r2;
  logic [SQ_BITS-1:0]    d2;
  logic [SQ_BITS-1:0]    radicand;
  logic [REM_BITS-1:0]   rem;
  logic [REM_BITS+1:0]   rem_sh;
  logic [REM_BITS+1:0]   trial;
  logic [REM_BITS+1:0]   diff;
  logic                  ge;
  logic [CNT_BITS-1:0]   cnt;

  // Row distance from the center never exceeds the radius.
  assign dy_wide = (row_pos >= X_BITS'(center_y)) ? row_pos - X_BITS'(center_y)
                                                  : X_BITS'(center_y) - row_pos;
  assign dy      = dy_wide[RAD_BITS-1:0];

  assign rem_sh  = {rem, radicand[SQ_BITS-1 -: 2]};
  assign trial   = (REM_BITS+2)'({root, 2'b01});
  assign ge      = rem_sh >= trial;
  assign diff    = rem_sh - trial;
  assign done    = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      r2 <= SQ_BITS'(radius) * SQ_BITS'(radius);
      d2 <= SQ_BITS'(dy) * SQ_BITS'(dy);
    end
    if (cmd.load_en) begin
      radicand <= r2 - d2;
      rem      <= '0;
      root     <= '0;
    end else if (cmd.iter_en) begin
      radicand <= radicand << 2;
      rem      <= ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
      root     <= {root[RAD_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load_en) begin
      cnt <= CNT_BITS'(RAD_BITS - 1);
    end else if (cmd.iter_en && !done) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

>>> hw/rtl/spr_dp.sv
// Datapath: shape registers, frame registers, walk logic and output register.
module spr_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [spr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [spr_pkg::COORD_BITS-1:0]   cfg_data,
  input  logic [spr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [spr_pkg::IN_USER_W-1:0]    s_tuser,
  input  spr_pkg::dp_cmd_t                 cmd,
  output spr_pkg::dp_status_t              st,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast
);
  import spr_pkg::*;

  req_t                  in_req;
  shape_t                in_kind;
  logic [COORD_BITS-1:0] in_cx;
  logic [COORD_BITS-1:0] in_cy;
  logic [RAD_BITS-1:0]   in_rad;
  logic [COLOR_BITS-1:0] in_color;

  logic [COORD_BITS-1:0] frame_cols;
  logic [COORD_BITS-1:0] frame_rows;

  logic                  busy, busy_next;
  shape_t                cur_shape, cur_shape_next;
  logic [COORD_BITS-1:0] cur_cx, cur_cx_next;
  logic [COORD_BITS-1:0] cur_cy, cur_cy_next;
  logic [RAD_BITS-1:0]   cur_rad, cur_rad_next;
  logic [COLOR_BITS-1:0] cur_color, cur_color_next;
  logic [X_BITS-1:0]     row_pos, row_pos_next;
  logic [X_BITS-1:0]     col_pos, col_pos_next;
  logic [RAD_BITS-1:0]   half_span, half_span_next;
  logic                  side_phase, side_phase_next;

  logic [X_BITS-1:0]     x_plus, x_minus, bottom_row;
  logic                  at_bottom, disc_row_end, fill_col_end, fill_row_end;
  logic [X_BITS-1:0]     tk_x, tk_y;
  logic                  tk_last;
  logic                  out_load;
  logic [RAD_BITS-1:0]   root;
  logic                  row_start;
  logic                  iter_done;

  logic                  out_valid;
  logic [X_BITS-1:0]     out_x, out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  assign in_req   = req_t'(s_tuser[0]);
  assign in_kind  = shape_t'(s_tuser[2:1]);
  assign in_cx    = s_tdata[CX_LSB +: COORD_BITS];
  assign in_cy    = s_tdata[CY_LSB +: COORD_BITS];
  assign in_rad   = s_tdata[RAD_LSB +: RAD_BITS];
  assign in_color = s_tdata[COL_LSB +: COLOR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= FRAME_COLS_RST;
      frame_rows <= FRAME_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COLS: frame_cols <= cfg_data;
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  spr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .row_pos  (row_pos),
    .center_y (cur_cy),
    .radius   (cur_rad),
    .root     (root),
    .done     (iter_done)
  );

  assign x_plus       = X_BITS'(cur_cx) + X_BITS'(half_span);
  assign x_minus      = X_BITS'(cur_cx) - X_BITS'(half_span);
  assign bottom_row   = X_BITS'(cur_cy) + X_BITS'(cur_rad);
  assign at_bottom    = (row_pos == bottom_row);
  assign disc_row_end = (col_pos == x_plus);
  assign fill_col_end = ((X_BITS+1)'(col_pos) + (X_BITS+1)'(1)) >= (X_BITS+1)'(frame_cols);
  assign fill_row_end = ((X_BITS+1)'(row_pos) + (X_BITS+1)'(1)) >= (X_BITS+1)'(frame_rows);

  // Pixel of the current tick
  always_comb begin
    tk_x    = col_pos;
    tk_y    = row_pos;
    tk_last = 1'b0;
    case (cur_shape)
      SHAPE_PIXEL: begin
        tk_x    = X_BITS'(cur_cx);
        tk_y    = X_BITS'(cur_cy);
        tk_last = 1'b1;
      end
      SHAPE_OUTLINE: begin
        tk_x    = side_phase ? x_minus : x_plus;
        tk_last = side_phase && at_bottom;
      end
      SHAPE_DISC: tk_last = disc_row_end && at_bottom;
      default:    tk_last = fill_col_end && fill_row_end;
    endcase
  end

  // Flag beats that open a circle row and so need a new half span
  always_comb begin
    if (in_req == REQ_CMD) begin
      row_start = ((in_kind == SHAPE_OUTLINE) || (in_kind == SHAPE_DISC)) &&
                  (in_cy >= COORD_BITS'(in_rad));
    end else begin
      row_start = busy && !at_bottom &&
                  (((cur_shape == SHAPE_OUTLINE) && side_phase) ||
                   ((cur_shape == SHAPE_DISC) && disc_row_end));
    end
  end

  always_comb begin
    busy_next       = busy;
    cur_shape_next  = cur_shape;
    cur_cx_next     = cur_cx;
    cur_cy_next     = cur_cy;
    cur_rad_next    = cur_rad;
    cur_color_next  = cur_color;
    row_pos_next    = row_pos;
    col_pos_next    = col_pos;
    half_span_next  = half_span;
    side_phase_next = side_phase;
    if (cmd.accept) begin
      if (in_req == REQ_CMD) begin
        cur_shape_next  = in_kind;
        cur_cx_next     = in_cx;
        cur_cy_next     = in_cy;
        cur_rad_next    = in_rad;
        cur_color_next  = in_color;
        busy_next       = 1'b1;
        side_phase_next = 1'b0;
        case (in_kind)
          SHAPE_OUTLINE, SHAPE_DISC: begin
            if (in_cy < COORD_BITS'(in_rad)) begin
              busy_next = 1'b0;
            end else begin
              row_pos_next = X_BITS'(in_cy - COORD_BITS'(in_rad));
            end
          end
          SHAPE_FILL: begin
            row_pos_next = '0;
            col_pos_next = '0;
            busy_next    = (frame_cols != '0) && (frame_rows != '0);
          end
          default: ;
        endcase
      end else if (busy) begin
        case (cur_shape)
          SHAPE_PIXEL: busy_next = 1'b0;
          SHAPE_OUTLINE: begin
            if (!side_phase) begin
              side_phase_next = 1'b1;
            end else if (at_bottom) begin
              busy_next = 1'b0;
            end else begin
              row_pos_next = row_pos + 1'b1;
            end
          end
          SHAPE_DISC: begin
            if (!disc_row_end) begin
              col_pos_next = col_pos + 1'b1;
            end else if (at_bottom) begin
              busy_next = 1'b0;
            end else begin
              row_pos_next = row_pos + 1'b1;
            end
          end
          default: begin
            if (!fill_col_end) begin
              col_pos_next = col_pos + 1'b1;
            end else if (fill_row_end) begin
              busy_next = 1'b0;
            end else begin
              col_pos_next = '0;
              row_pos_next = row_pos + 1'b1;
            end
          end
        endcase
      end
    end
    if (cmd.span_en) begin
      half_span_next  = root;
      col_pos_next    = X_BITS'(cur_cx) - X_BITS'(root);
      side_phase_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_shape  <= cur_shape_next;
    cur_cx     <= cur_cx_next;
    cur_cy     <= cur_cy_next;
    cur_rad    <= cur_rad_next;
    cur_color  <= cur_color_next;
    row_pos    <= row_pos_next;
    col_pos    <= col_pos_next;
    half_span  <= half_span_next;
    side_phase <= side_phase_next;
  end

  assign out_load = cmd.accept && (in_req == REQ_TICK) && busy;
  assign st       = '{out_free: (!out_valid || m_tready),
                      row_start: row_start,
                      iter_done: iter_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x     <= tk_x;
      out_y     <= tk_y;
      out_color <= cur_color;
      out_last  <= tk_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_color, out_y, out_x});
  assign m_tlast  = out_last;

endmodule

>>> hw/rtl/spr_ctrl.sv
// Controller: input acceptance and sequencing of the half-span unit.
module spr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  spr_pkg::dp_status_t st,
  output spr_pkg::dp_cmd_t    cmd
);
  import spr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_READY: begin
        if (s_tvalid && s_tready && st.row_start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ITER;
      ST_ITER: begin
        if (st.iter_done) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN: state_next = ST_READY;
      default: state_next = ST_READY;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_READY: begin
        s_tready   = st.out_free;
        cmd.accept = s_tvalid && st.out_free;
      end
      ST_MUL:  cmd.mul_en  = 1'b1;
      ST_LOAD: cmd.load_en = 1'b1;
      ST_ITER: cmd.iter_en = 1'b1;
      ST_SPAN: cmd.span_en = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/shape_pixel_rasterizer_unit.sv
// Shape pixel rasterizer: top level joining controller and datapath.
//
// Usage: send a command beat (tuser req_type = 0) carrying shape kind, center,
// radius and color; it produces no output. Each later tick beat (req_type = 1)
// yields at most one pixel beat on the master side; tlast marks the final
// pixel of the shape. A tick with no shape in progress yields nothing, and a
// new command drops the shape in progress. The frame columns (cfg index 0) and
// rows (cfg index 1) are written through the cfg port and bound whole-frame fills.
//
// A tick that stays within a circle row, a single pixel or a fill is taken
// without the half-span unit; its pixel appears on m_tdata the cycle after acceptance.
// A circle command whose center_y is not below its radius, and a tick that finishes
// a circle row other than the last, start the half-span unit: it squares, loads,
// runs eleven root iterations (one result bit each) and stores the span, and
// s_tready stays low while it runs.
//
// Reset (rst, synchronous) empties the output register, clears the shape in
// progress and restores the frame to 640 x 480. When the receiver stalls, the
// finished pixel holds in the output register and s_tready drops until it is
// taken; a beat is still accepted in the cycle the pending pixel drains.
module shape_pixel_rasterizer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [spr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [spr_pkg::COORD_BITS-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // center_x[11:0], center_y[23:12], radius[34:24], color[42:35], zero pad
  input  logic [spr_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type[0], shape_kind[2:1]
  input  logic [spr_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[39:32]
  output logic [spr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast
);
  import spr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Controller owns the input handshake and the half-span sequence
  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath holds all shape state and the output register
  spr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> hw/rtl/spr_checker.sv
// Port-level checker for the shape pixel rasterizer, bound to the top level.
`include "shape_pixel_rasterizer_unit_macros.svh"

module spr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [spr_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [spr_pkg::IN_USER_W-1:0]  s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [spr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import spr_pkg::*;

  logic s_fire, s_cmd, s_tick, s_pix_cmd;

  assign s_fire    = s_tvalid && s_tready;
  assign s_cmd     = s_fire && (s_tuser[0] == REQ_CMD);
  assign s_tick    = s_fire && (s_tuser[0] == REQ_TICK);
  assign s_pix_cmd = s_cmd && (s_tuser[2:1] == SHAPE_PIXEL);

  // A stalled pixel beat holds
  `SPR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Reset empties the output register
  `SPR_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid)

  // A command beat never produces a pixel
  `SPR_ASSERT(a_cmd_silent, s_cmd |=> !m_tvalid)

  // A single-pixel command answers its first tick with the last pixel at its center column
  `SPR_ASSERT(a_pixel_shape, s_pix_cmd ##1 s_tick |=> m_tvalid && m_tlast && m_tdata[X_BITS-1:0] == X_BITS'($past(s_tdata[COORD_BITS-1:0], 2)))

endmodule

bind shape_pixel_rasterizer_unit spr_checker u_spr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
